// File: rtl/btt_pkg.sv
// Shared types and constants for the branch target table check block.
`timescale 1ns / 1ps
`default_nettype none
package btt_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = 64;
  localparam int CMD_W       = 2;
  localparam int IN_DATA_W   = 2 * ADDR_W;
  localparam int OUT_DATA_W  = 16;

  localparam logic [CMD_W-1:0] CMD_CHECK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RANGE = 2'd2;

  typedef enum logic [1:0] {
    VERDICT_VALID   = 2'd0,
    VERDICT_INVALID = 2'd1,
    VERDICT_UNKNOWN = 2'd2,
    VERDICT_NONE    = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    OP_CHECK,
    OP_PUSH,
    OP_RANGE,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] range_high;
  } req_t;

  typedef enum logic {
    BK_IDLE,
    BK_PROBE
  } back_state_t;

endpackage
`default_nettype wire

// File: rtl/btt_front.sv
// Front stage: accepts requests, decodes the command and registers them.
`timescale 1ns / 1ps
`default_nettype none
module btt_front
  import btt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata,  // address, range_high
  input  wire logic [CMD_W-1:0]     s_axis_tuser,  // cmd
  output      logic                 req_valid,
  input  wire logic                 req_ready,
  output      req_t                 req
);

  logic vld;
  op_t  op_dec;

  always_comb begin
    case (s_axis_tuser)
      CMD_CHECK: op_dec = OP_CHECK;
      CMD_PUSH:  op_dec = OP_PUSH;
      CMD_RANGE: op_dec = OP_RANGE;
      default:   op_dec = OP_NONE;
    endcase
  end

  assign s_axis_tready = !vld || req_ready;
  assign req_valid     = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (s_axis_tready) begin
      vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req.op         <= op_dec;
      req.address    <= s_axis_tdata[ADDR_W-1:0];
      req.range_high <= s_axis_tdata[IN_DATA_W-1:ADDR_W];
    end
  end

endmodule
`default_nettype wire

// File: rtl/btt_queue.sv
// Two-entry request queue between the front and back stages.
`timescale 1ns / 1ps
`default_nettype none
module btt_queue
  import btt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output      logic in_ready,
  input  wire req_t in_req,
  output      logic out_valid,
  input  wire logic out_ready,
  output      req_t out_req
);

  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_req   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_req;
    end
  end

endmodule
`default_nettype wire

// File: rtl/btt_back.sv
// Back stage: target table, window registers, binary search and result register.
`timescale 1ns / 1ps
`default_nettype none
module btt_back
  import btt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output      logic                  req_ready,
  input  wire req_t                  req,
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output      logic [OUT_DATA_W-1:0] m_axis_tdata  // verdict, table_full, entry_count
);

  function automatic logic [CNT_W-1:0] mid_of(input logic [CNT_W-1:0] lo_v,
                                               input logic [CNT_W-1:0] hi_v);
    logic [CNT_W:0] sum;
    sum = {1'b0, lo_v} + {1'b0, hi_v} - {{CNT_W{1'b0}}, 1'b1};
    return sum[CNT_W:1];
  endfunction

  logic [ADDR_W-1:0] mem [TABLE_DEPTH];
  logic [ADDR_W-1:0] rdata;

  back_state_t       state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] win_low, win_low_next;
  logic [ADDR_W-1:0] win_high, win_high_next;
  logic [CNT_W-1:0]  lo, lo_next;
  logic [CNT_W-1:0]  hi_ex, hi_ex_next;
  logic [CNT_W-1:0]  mid, mid_next;
  logic [ADDR_W-1:0] key, key_next;

  logic              out_free;
  logic              out_load;
  verdict_t          res_verdict;
  logic              res_full;
  logic              wr_en;
  logic              rd_en;
  logic [CNT_W-1:0]  probe_lo;
  logic [CNT_W-1:0]  probe_hi;
  logic [CNT_W-1:0]  mid_new;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign mid_new  = mid_of(probe_lo, probe_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      count    <= '0;
      win_low  <= '1;
      win_high <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      win_low  <= win_low_next;
      win_high <= win_high_next;
    end
  end

  always_ff @(posedge clk) begin
    lo    <= lo_next;
    hi_ex <= hi_ex_next;
    mid   <= mid_next;
    key   <= key_next;
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    win_low_next  = win_low;
    win_high_next = win_high;
    lo_next       = lo;
    hi_ex_next    = hi_ex;
    mid_next      = mid;
    key_next      = key;
    req_ready     = 1'b0;
    out_load      = 1'b0;
    res_verdict   = VERDICT_NONE;
    res_full      = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    probe_lo      = '0;
    probe_hi      = count;
    case (state)
      BK_IDLE: begin
        req_ready = out_free;
        if (req_valid && out_free) begin
          case (req.op)
            OP_CHECK: begin
              if (req.address < win_low || req.address > win_high) begin
                out_load    = 1'b1;
                res_verdict = VERDICT_UNKNOWN;
              end else if (count == '0) begin
                out_load    = 1'b1;
                res_verdict = VERDICT_INVALID;
              end else begin
                key_next   = req.address;
                lo_next    = '0;
                hi_ex_next = count;
                mid_next   = mid_new;
                rd_en      = 1'b1;
                state_next = BK_PROBE;
              end
            end
            OP_PUSH: begin
              out_load = 1'b1;
              if (count == CNT_W'(TABLE_DEPTH)) begin
                res_full = 1'b1;
              end else begin
                wr_en      = 1'b1;
                count_next = count + 1'b1;
              end
            end
            OP_RANGE: begin
              out_load = 1'b1;
              if (req.address < win_low) win_low_next = req.address;
              if (req.range_high > win_high) win_high_next = req.range_high;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      BK_PROBE: begin
        if (rdata < key) begin
          probe_lo = mid + 1'b1;
          probe_hi = hi_ex;
        end else begin
          probe_lo = lo;
          probe_hi = mid;
        end
        if (rdata == key) begin
          out_load    = 1'b1;
          res_verdict = VERDICT_VALID;
          state_next  = BK_IDLE;
        end else if (probe_lo < probe_hi) begin
          lo_next    = probe_lo;
          hi_ex_next = probe_hi;
          mid_next   = mid_new;
          rd_en      = 1'b1;
        end else begin
          out_load    = 1'b1;
          res_verdict = VERDICT_INVALID;
          state_next  = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IDX_W-1:0]] <= req.address;
    end
    if (rd_en) begin
      rdata <= mem[mid_new[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {count_next, res_full, res_verdict};
    end
  end

endmodule
`default_nettype wire

// File: rtl/branch_target_table_check.sv
// Top level of the branch target table check block.
// Path: push, range and other non-check requests pass the front register and the queue to the result register;
//   a check then runs its binary search probes, each a registered read of the target table.
// Throughput: non-check requests one per cycle while no check is in progress and the result output is not
//   stalled; a check holds the table for all its probes, as the target table has a single registered read port.
// Reset (rst, synchronous): entry count zero, window empty, queue and result cleared;
//   table contents are not cleared and are only read below the entry count.
`timescale 1ns / 1ps
`default_nettype none
module branch_target_table_check
  import btt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // address[63:0], range_high[127:64]
  input  wire logic [CMD_W-1:0]      s_axis_tuser,  // cmd[1:0]
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output      logic [OUT_DATA_W-1:0] m_axis_tdata   // verdict[1:0], table_full[2],
                                                    // entry_count[15:3]
);

  logic fr_valid;
  logic fr_ready;
  req_t fr_req;
  logic bk_valid;
  logic bk_ready;
  req_t bk_req;

  btt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .req_valid     (fr_valid),
    .req_ready     (fr_ready),
    .req           (fr_req)
  );

  btt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_req    (fr_req),
    .out_valid (bk_valid),
    .out_ready (bk_ready),
    .out_req   (bk_req)
  );

  btt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (bk_valid),
    .req_ready     (bk_ready),
    .req           (bk_req),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire

// File: tb/tb_branch_target_table_check.sv
// Self-checking testbench for the branch target table check block.
`timescale 1ns / 1ps
module tb_branch_target_table_check;
  import btt_pkg::*;

  localparam int RANDOM_ITEMS = 1830;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    verdict_t         verdict;
  } result_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // address[63:0], range_high[127:64]
  logic [CMD_W-1:0]      s_axis_tuser  = '0;  // cmd[1:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // verdict[1:0], table_full[2], entry_count[15:3]

  // predictor state
  logic [ADDR_W-1:0] allowed_targets [TABLE_DEPTH];
  int                target_count = 0;
  logic [ADDR_W-1:0] window_low   = '1;
  logic [ADDR_W-1:0] window_high  = '0;
  logic [ADDR_W-1:0] next_target  = '0;

  result_t expected_results [$];
  int      errors     = 0;
  bit      idle_on    = 1'b1;
  int      stall_left = 0;

  branch_target_table_check i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic verdict_t search_targets(logic [ADDR_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = target_count - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (allowed_targets[mid] < key) lo = mid + 1;
      else if (allowed_targets[mid] > key) hi = mid - 1;
      else return VERDICT_VALID;
    end
    return VERDICT_INVALID;
  endfunction

  function automatic result_t apply_request(op_t op, logic [ADDR_W-1:0] addr,
                                            logic [ADDR_W-1:0] rhigh);
    result_t res;
    res.verdict = VERDICT_NONE;
    res.full    = 1'b0;
    case (op)
      OP_CHECK: begin
        if (addr < window_low || addr > window_high) res.verdict = VERDICT_UNKNOWN;
        else res.verdict = search_targets(addr);
      end
      OP_PUSH: begin
        if (target_count >= TABLE_DEPTH) begin
          res.full = 1'b1;
        end else begin
          allowed_targets[target_count] = addr;
          target_count++;
        end
      end
      OP_RANGE: begin
        if (addr < window_low) window_low = addr;
        if (rhigh > window_high) window_high = rhigh;
      end
      default: ;
    endcase
    res.count = CNT_W'(target_count);
    return res;
  endfunction

  // Call right after a rising edge; returns at the edge where the request is accepted.
  task automatic send_request(op_t op, logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] rhigh);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rhigh, addr};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_results.push_back(apply_request(op, addr, rhigh));
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] stored_target();
    if (target_count == 0) return next_target;
    return allowed_targets[$urandom_range(0, target_count - 1)];
  endfunction

  always @(posedge clk) begin
    result_t act;
    result_t exp;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      act = result_t'(m_axis_tdata);
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, m_axis_tdata);
        errors++;
      end else begin
        exp = expected_results.pop_front();
        if (act.verdict !== exp.verdict) begin
          $display("%0t: verdict expected %0d actual %0d", $time, exp.verdict, act.verdict);
          errors++;
        end
        if (act.full !== exp.full) begin
          $display("%0t: table_full expected %0d actual %0d", $time, exp.full, act.full);
          errors++;
        end
        if (act.count !== exp.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, exp.count, act.count);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // window starts empty: every check is unknown, even on the extremes
  task automatic test_empty_window();
    send_request(OP_CHECK, '0, rand64());
    send_request(OP_CHECK, '1, rand64());
    send_request(OP_CHECK, rand64(), rand64());
    send_request(OP_NONE, rand64(), rand64());
    send_request(OP_RANGE, '1, '0);
    send_request(OP_CHECK, 64'h1800, '0);
  endtask

  task automatic test_window_and_lookup();
    send_request(OP_RANGE, 64'h1000, 64'h2000);
    send_request(OP_PUSH, '0, '1);
    send_request(OP_PUSH, 64'h1000, '0);
    send_request(OP_PUSH, 64'h1800, '0);
    send_request(OP_PUSH, 64'h2000, '0);
    send_request(OP_CHECK, '0, '0);
    send_request(OP_CHECK, 64'h0fff, '0);
    send_request(OP_CHECK, 64'h1000, '0);
    send_request(OP_CHECK, 64'h1001, '0);
    send_request(OP_CHECK, 64'h1800, '0);
    send_request(OP_CHECK, 64'h2000, '0);
    send_request(OP_CHECK, 64'h2001, '0);
    send_request(OP_NONE, '1, '1);
    send_request(OP_RANGE, 64'h1800, 64'h1800);
    send_request(OP_CHECK, 64'h0fff, '1);
    next_target = 64'h2000;
  endtask

  task automatic test_random_traffic();
    int                pick;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 200 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (n % 450 == 449) wait_results_drained();
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        next_target += $urandom_range(1, 65536);
        send_request(OP_PUSH, next_target, rand64());
      end else if (pick < 33) begin
        send_request(OP_PUSH, rand64(), rand64());
      end else if (pick < 39) begin
        lo = (window_low > 300) ? window_low - $urandom_range(0, 256) : window_low;
        hi = (window_high > next_target) ? window_high : next_target;
        hi += $urandom_range(0, 65536);
        send_request(OP_RANGE, lo, hi);
      end else if (pick < 42) begin
        send_request(OP_NONE, rand64(), rand64());
      end else if (pick < 67) begin
        send_request(OP_CHECK, stored_target(), rand64());
      end else if (pick < 80) begin
        if ($urandom_range(0, 1)) send_request(OP_CHECK, stored_target() + 1, rand64());
        else send_request(OP_CHECK, stored_target() - 1, rand64());
      end else if (pick < 90) begin
        if ($urandom_range(0, 1)) send_request(OP_CHECK, window_low - 1, rand64());
        else send_request(OP_CHECK, window_high + 1, rand64());
      end else begin
        send_request(OP_CHECK, rand64(), rand64());
      end
    end
  endtask

  // fill to capacity, push past it, then search the full table
  task automatic test_full_table();
    idle_on = 1'b0;
    send_request(OP_RANGE, '0, '1);
    while (target_count < TABLE_DEPTH - 1) begin
      next_target += $urandom_range(1, 65536);
      send_request(OP_PUSH, next_target, rand64());
    end
    send_request(OP_PUSH, '1, '0);
    repeat (3) send_request(OP_PUSH, rand64(), rand64());
    send_request(OP_CHECK, '0, '0);
    send_request(OP_CHECK, '1, '0);
    repeat (40) send_request(OP_CHECK, stored_target(), rand64());
    repeat (10) send_request(OP_CHECK, stored_target() + 1, rand64());
    repeat (10) send_request(OP_CHECK, rand64(), rand64());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_window();
    test_window_and_lookup();
    wait_results_drained();
    test_random_traffic();
    test_full_table();
    wait_results_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: files.f
rtl/btt_pkg.sv
rtl/btt_front.sv
rtl/btt_queue.sv
rtl/btt_back.sv
rtl/branch_target_table_check.sv
tb/tb_branch_target_table_check.sv
